@@ hdl/lpc_pkg.sv @@
// shared constants and types of the local peak clipping filter
package lpc_pkg;

    // line store depth and pixel width
    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 31;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);

    // configuration register widths
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_DATA_BITS = (WIDTH_BITS > HEIGHT_BITS) ? WIDTH_BITS : HEIGHT_BITS;
    localparam int CFG_INDEX_BITS = 1;

    // effective width arithmetic must hold both the register and MAX_WIDTH
    localparam int EW_BITS = (WIDTH_BITS > COL_BITS + 1) ? WIDTH_BITS : COL_BITS + 1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // item operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // per-item control decided by the raster scan
    typedef struct packed {
        logic                take;
        logic [COL_BITS-1:0] col;
        logic                last_col;
        logic                up_en;
        logic                emit;
        logic                frame_end;
        logic                draining;
    } lpc_step_t;

endpackage

@@ hdl/lpc_pixel_if.sv @@
// input item channel: operation and pixel
interface lpc_pixel_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [lpc_pkg::PIXEL_BITS-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink (input valid, input op, input pixel, output ready);
endinterface

@@ hdl/lpc_result_if.sv @@
// result item channel: clipped pixel and frame end mark
interface lpc_result_if;
    logic                          valid;
    logic                          ready;
    logic [lpc_pkg::PIXEL_BITS-1:0] clipped;
    logic                          frame_end;

    modport source (output valid, output clipped, output frame_end, input ready);
    modport sink (input valid, input clipped, input frame_end, output ready);
endinterface

@@ hdl/lpc_ram.sv @@
// generic ram: one write port, two registered read ports
module lpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered reads, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

@@ hdl/lpc_scan_ctrl.sv @@
// configuration registers and raster scan counters
module lpc_scan_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lpc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               accept,
    input  logic                               op,
    output lpc_pkg::lpc_step_t                 step
);
    import lpc_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [HEIGHT_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic                   draining_reg, draining_next;

    logic [EW_BITS-1:0]     width_ext;
    logic [EW_BITS-1:0]     eff_width;
    logic [EW_BITS-1:0]     col_ext;
    logic [HEIGHT_BITS-1:0] eff_height;
    logic [HEIGHT_BITS-1:0] row_inc;
    logic [COL_BITS-1:0]    col_now;
    logic                   last_col;
    logic                   take;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_BITS'(1);
            height_reg <= HEIGHT_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // effective frame size, zero read as one, width clamped to the line store
    always_comb
    begin
        width_ext = EW_BITS'(width_reg);
        if (width_ext == '0)
        begin
            eff_width = EW_BITS'(1);
        end
        else if (width_ext > EW_BITS'(MAX_WIDTH))
        begin
            eff_width = EW_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        eff_height = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;
    end

    // current column, saturated when the width shrank mid-row
    always_comb
    begin
        col_ext  = EW_BITS'(col_reg);
        col_now  = (col_ext < eff_width) ? col_reg : COL_BITS'(eff_width - EW_BITS'(1));
        last_col = (EW_BITS'(col_now) + EW_BITS'(1)) >= eff_width;
        take     = !(op == OP_DRAIN && !draining_reg);
        row_inc  = row_reg + HEIGHT_BITS'(1);
    end

    // step control for the item at the input
    always_comb
    begin
        step.take      = take;
        step.col       = col_now;
        step.last_col  = last_col;
        step.up_en     = row_reg >= HEIGHT_BITS'(2);
        step.emit      = draining_reg || (row_reg != '0);
        step.frame_end = draining_reg && last_col;
        step.draining  = draining_reg;
    end

    // counter advance on a taken item
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        draining_next = draining_reg;
        if (accept && take)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (draining_reg)
                begin
                    draining_next = 1'b0;
                    row_next      = '0;
                end
                else
                begin
                    row_next = row_inc;
                    if (row_inc >= eff_height)
                    begin
                        draining_next = 1'b1;
                    end
                end
            end
            else
            begin
                col_next = col_now + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            draining_reg <= draining_next;
        end
    end

endmodule

@@ hdl/local_peak_clip_filter.sv @@
// top level of the four-neighbour local peak clipping filter
//
//   channel   direction  handshake      payload
//   pixels    in         valid/ready    op, pixel
//   results   out        valid/ready    clipped, frame_end
//   cfg       in         cfg_wr_en      cfg_index, cfg_data
//
// one item per cycle sustained while results are accepted; a taken item passes through
// the middle stage (line store read), then the result register.
// the line stores use one write and two read ports each, which sets the rate.
// reset clears the scan counters and valid flags; line stores are not cleared.
// a stalled result register holds the middle stage, which holds off new items.
module local_peak_clip_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lpc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    lpc_pixel_if.sink                          pixels,
    lpc_result_if.source                       results
);
    import lpc_pkg::*;

    lpc_step_t step;

    logic accept;
    logic take;
    logic s2_adv;

    // middle stage: control and bypass for the item whose line data is read
    logic                  s2_valid_reg, s2_valid_next;
    logic [COL_BITS-1:0]   s2_col_reg;
    logic [PIXEL_BITS-1:0] s2_down_reg;
    logic                  s2_up_en_reg;
    logic                  s2_left_en_reg;
    logic                  s2_right_en_reg;
    logic                  s2_emit_reg;
    logic                  s2_frame_end_reg;
    logic                  byp_same_reg;
    logic                  byp_left_reg;
    logic                  byp_right_reg;
    logic [PIXEL_BITS-1:0] byp_centre_reg;
    logic [PIXEL_BITS-1:0] byp_down_reg;

    // result register
    logic                  res_valid_reg, res_valid_next;
    logic [PIXEL_BITS-1:0] res_clipped_reg;
    logic                  res_frame_end_reg;

    logic [COL_BITS-1:0]   addr_prev;
    logic [COL_BITS-1:0]   addr_succ;
    logic [PIXEL_BITS-1:0] upper_rd_a, upper_rd_b;
    logic [PIXEL_BITS-1:0] middle_rd_a, middle_rd_b;
    logic [PIXEL_BITS-1:0] centre, up, down_in, left, right;
    logic [PIXEL_BITS-1:0] max_ud, max_lr, nmax, clip;

    lpc_scan_ctrl u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .op        (pixels.op),
        .step      (step)
    );

    // handshake and stage advance
    always_comb
    begin
        s2_adv        = s2_valid_reg && (!s2_emit_reg || !res_valid_reg || results.ready);
        pixels.ready  = !s2_valid_reg || s2_adv;
        accept        = pixels.valid && pixels.ready;
        take          = accept && step.take;
        addr_prev     = step.col - COL_BITS'(1);
        addr_succ     = step.col + COL_BITS'(1);
        down_in       = step.draining ? '0 : pixels.pixel;
    end

    // row above the centre row, after its own update it holds the centre row
    lpc_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk       (clk),
        .wr_en     (s2_adv),
        .wr_addr   (s2_col_reg),
        .wr_data   (centre),
        .rd_en     (take),
        .rd_addr_a (step.col),
        .rd_addr_b (addr_prev),
        .rd_data_a (upper_rd_a),
        .rd_data_b (upper_rd_b)
    );

    // centre row, refilled with the incoming row
    lpc_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk       (clk),
        .wr_en     (s2_adv),
        .wr_addr   (s2_col_reg),
        .wr_data   (s2_down_reg),
        .rd_en     (take),
        .rd_addr_a (step.col),
        .rd_addr_b (addr_succ),
        .rd_data_a (middle_rd_a),
        .rd_data_b (middle_rd_b)
    );

    // neighbour selection with forwarding of the write done at read time
    always_comb
    begin
        centre = byp_same_reg ? byp_down_reg : middle_rd_a;
        up     = s2_up_en_reg ? (byp_same_reg ? byp_centre_reg : upper_rd_a) : '0;
        left   = s2_left_en_reg ? (byp_left_reg ? byp_centre_reg : upper_rd_b) : '0;
        right  = s2_right_en_reg ? (byp_right_reg ? byp_down_reg : middle_rd_b) : '0;
        max_ud = (up > s2_down_reg) ? up : s2_down_reg;
        max_lr = (left > right) ? left : right;
        nmax   = (max_ud > max_lr) ? max_ud : max_lr;
        clip   = (centre < nmax) ? centre : nmax;
    end

    // middle stage valid
    always_comb
    begin
        priority if (take)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    // middle stage payload and bypass capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_col_reg       <= step.col;
            s2_down_reg      <= down_in;
            s2_up_en_reg     <= step.up_en;
            s2_left_en_reg   <= step.col != '0;
            s2_right_en_reg  <= !step.last_col;
            s2_emit_reg      <= step.emit;
            s2_frame_end_reg <= step.frame_end;
            byp_same_reg     <= s2_adv && (step.col == s2_col_reg);
            byp_left_reg     <= s2_adv && (addr_prev == s2_col_reg);
            byp_right_reg    <= s2_adv && (addr_succ == s2_col_reg);
            byp_centre_reg   <= centre;
            byp_down_reg     <= s2_down_reg;
        end
    end

    // result register valid
    always_comb
    begin
        priority if (s2_adv && s2_emit_reg)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_emit_reg)
        begin
            res_clipped_reg   <= clip;
            res_frame_end_reg <= s2_frame_end_reg;
        end
    end

    // result outputs
    assign results.valid     = res_valid_reg;
    assign results.clipped   = res_clipped_reg;
    assign results.frame_end = res_frame_end_reg;

`ifndef SYNTHESIS
    // a held middle stage blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_adv |-> !pixels.ready)
        else $error("item taken while middle stage is stalled");

    // only the drain row can end a frame, and it always gives a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_frame_end_reg |-> s2_emit_reg)
        else $error("frame end on an item without a result");

    // the final drain step returns the scan to a new frame
    assert property (@(posedge clk) disable iff (!rst_n)
        take && step.frame_end |=> !step.draining)
        else $error("drain not left after frame end");

    // a new result appears only from an advancing middle stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s2_adv && s2_emit_reg))
        else $error("result valid without a source item");
`endif

endmodule
